>>> src/mtts_pkg.sv
// Shared types and constants for the transition table sampler.
`timescale 1ns / 1ps

package mtts_pkg;

    localparam int ACTION_W = 1;
    localparam int TSEL_W   = 3;
    localparam int VALUE_W  = 8;
    localparam int FRAC_W   = 16;
    localparam int TOTAL_W  = 32;
    localparam int LHS_W    = FRAC_W + TOTAL_W;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_RECORD = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_DRAW   = 1'b1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [TSEL_W-1:0]   table_select;
        logic [VALUE_W-1:0]  from_value;
        logic [VALUE_W-1:0]  to_value;
        logic [FRAC_W-1:0]   random_fraction;
    } req_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] next_value;
        logic               row_empty;
    } rsp_item_t;

endpackage

>>> src/markov_transition_table_sampler_core.sv
// Transition count tables with record (increment) and inverse-CDF draw operations.
// Sequence: a record reads the count and row total, then writes both; a draw reads the row total,
// walks the row unless it is empty, and pushes the result; an out-of-range row goes straight to the push.
// Throughput: one item in work at a time; the row walk reads one count per cycle through a
// single read port, and a draw holds the input until its result is pushed, including result stalls.
// Reset: a clearing pass zeroes every count and row total; req_stall is high.
`timescale 1ns / 1ps

module markov_transition_table_sampler_core
    import mtts_pkg::*;
#(
    parameter int TABLES     = 8,
    parameter int VALUES     = 256,
    parameter int COUNT_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int ROWS   = TABLES * VALUES;
    localparam int CELLS  = ROWS * VALUES;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_AW = $clog2(CELLS);
    localparam int V_W    = $clog2(VALUES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REC_WR,
        S_TOT,
        S_WALK,
        S_PUSH
    } state_t;

    state_t                  state_reg;
    logic [CNT_AW-1:0]       clr_reg;
    logic [ROW_AW-1:0]       row_reg;
    logic [CNT_AW-1:0]       cell_reg;
    logic [CNT_AW-1:0]       base_reg;
    logic [FRAC_W-1:0]       frac_reg;
    logic [VALUE_W-1:0]      from_reg;
    logic [LHS_W-1:0]        lhs_reg;
    logic [TOTAL_W-1:0]      cum_reg;
    logic [V_W-1:0]          iss_reg;
    logic                    issue_on_reg;
    logic                    dv_reg;
    logic [V_W-1:0]          dv_idx_reg;
    logic                    cv_reg;
    logic [V_W-1:0]          cv_idx_reg;
    rsp_item_t               res_reg;
    logic                    rsp_valid_reg;
    rsp_item_t               rsp_reg;

    // memory ports
    logic                    cnt_we;
    logic [CNT_AW-1:0]       cnt_waddr;
    logic [COUNT_BITS-1:0]   cnt_wdata;
    logic [CNT_AW-1:0]       cnt_raddr;
    logic [COUNT_BITS-1:0]   cnt_rdata;
    logic                    tot_we;
    logic [ROW_AW-1:0]       tot_waddr;
    logic [TOTAL_W-1:0]      tot_wdata;
    logic [ROW_AW-1:0]       tot_raddr;
    logic [TOTAL_W-1:0]      tot_rdata;

    // request decode
    logic                    row_ok;
    logic                    to_ok;
    logic [31:0]             row_lin;
    logic [31:0]             base_lin;
    logic [ROW_AW-1:0]       req_row;
    logic [CNT_AW-1:0]       req_base;
    logic [CNT_AW-1:0]       req_cell;
    logic                    accept;
    logic                    do_inc;
    logic [LHS_W-1:0]        lhs_next;
    logic [TOTAL_W-1:0]      cum_next;
    logic [LHS_W-1:0]        cum_scaled;
    logic                    hit;

    assign accept   = req_valid && !req_stall;
    assign row_ok   = (32'(req.table_select) < 32'(TABLES))
                   && (32'(req.from_value) < 32'(VALUES));
    assign to_ok    = 32'(req.to_value) < 32'(VALUES);
    assign row_lin  = 32'(req.table_select) * 32'(VALUES) + 32'(req.from_value);
    assign base_lin = row_lin * 32'(VALUES);
    assign req_row  = row_lin[ROW_AW-1:0];
    assign req_base = base_lin[CNT_AW-1:0];
    assign req_cell = req_base + CNT_AW'(req.to_value);

    // increment only when neither the count nor the row total is saturated
    assign do_inc = (cnt_rdata != {COUNT_BITS{1'b1}}) && (tot_rdata != {TOTAL_W{1'b1}});

    // r * total, and cumulative * 65535 as a shift and subtract
    assign lhs_next   = frac_reg * tot_rdata;
    assign cum_next   = cum_reg + TOTAL_W'(cnt_rdata);
    assign cum_scaled = {cum_reg, {FRAC_W{1'b0}}} - {{FRAC_W{1'b0}}, cum_reg};
    assign hit        = cv_reg && (lhs_reg <= cum_scaled);

    // count memory port control
    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = cell_reg;
        cnt_wdata = cnt_rdata + COUNT_BITS'(1);
        cnt_raddr = base_reg + CNT_AW'(iss_reg);
        case (state_reg)
            S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
            end
            S_IDLE:
            begin
                cnt_raddr = req_cell;
            end
            S_REC_WR:
            begin
                cnt_we = do_inc;
            end
            default:
            begin
                cnt_we = 1'b0;
            end
        endcase
    end

    // row total memory port control
    always_comb
    begin
        tot_we    = 1'b0;
        tot_waddr = row_reg;
        tot_wdata = tot_rdata + TOTAL_W'(1);
        tot_raddr = req_row;
        case (state_reg)
            S_CLEAR:
            begin
                tot_we    = (32'(clr_reg) < 32'(ROWS));
                tot_waddr = clr_reg[ROW_AW-1:0];
                tot_wdata = '0;
            end
            S_REC_WR:
            begin
                tot_we = do_inc;
            end
            default:
            begin
                tot_we = 1'b0;
            end
        endcase
    end

    mtts_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (CELLS)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    mtts_ram #(
        .WIDTH (TOTAL_W),
        .DEPTH (ROWS)
    ) u_total_ram (
        .clk   (clk),
        .we    (tot_we),
        .waddr (tot_waddr),
        .wdata (tot_wdata),
        .raddr (tot_raddr),
        .rdata (tot_rdata)
    );

    // sequencer, row walk pipeline and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            row_reg       <= '0;
            cell_reg      <= '0;
            base_reg      <= '0;
            frac_reg      <= '0;
            from_reg      <= '0;
            lhs_reg       <= '0;
            cum_reg       <= '0;
            iss_reg       <= '0;
            issue_on_reg  <= 1'b0;
            dv_reg        <= 1'b0;
            dv_idx_reg    <= '0;
            cv_reg        <= 1'b0;
            cv_idx_reg    <= '0;
            res_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            // output slot drains on transfer; a push in the same cycle refills it instead
            if (rsp_valid_reg && !rsp_stall && state_reg != S_PUSH)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + CNT_AW'(1);
                    if (clr_reg == CNT_AW'(CELLS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    row_reg  <= req_row;
                    cell_reg <= req_cell;
                    base_reg <= req_base;
                    frac_reg <= req.random_fraction;
                    from_reg <= req.from_value;
                    if (accept)
                    begin
                        if (req.action == ACT_RECORD)
                        begin
                            if (row_ok && to_ok)
                            begin
                                state_reg <= S_REC_WR;
                            end
                        end
                        else if (row_ok)
                        begin
                            state_reg <= S_TOT;
                        end
                        else
                        begin
                            res_reg.next_value <= req.from_value;
                            res_reg.row_empty  <= 1'b1;
                            state_reg          <= S_PUSH;
                        end
                    end
                end

                S_REC_WR:
                begin
                    state_reg <= S_IDLE;
                end

                S_TOT:
                begin
                    lhs_reg      <= lhs_next;
                    cum_reg      <= '0;
                    iss_reg      <= '0;
                    dv_reg       <= 1'b0;
                    cv_reg       <= 1'b0;
                    if (tot_rdata == '0)
                    begin
                        res_reg.next_value <= from_reg;
                        res_reg.row_empty  <= 1'b1;
                        state_reg          <= S_PUSH;
                    end
                    else
                    begin
                        issue_on_reg <= 1'b1;
                        state_reg    <= S_WALK;
                    end
                end

                S_WALK:
                begin
                    // read issue
                    if (issue_on_reg)
                    begin
                        iss_reg <= iss_reg + V_W'(1);
                        if (iss_reg == V_W'(VALUES - 1))
                        begin
                            issue_on_reg <= 1'b0;
                        end
                    end
                    // data return
                    dv_reg     <= issue_on_reg;
                    dv_idx_reg <= iss_reg;
                    // accumulate
                    cv_reg     <= dv_reg;
                    cv_idx_reg <= dv_idx_reg;
                    if (dv_reg)
                    begin
                        cum_reg <= cum_next;
                    end
                    // first cumulative count reaching the scaled fraction
                    if (hit)
                    begin
                        res_reg.next_value <= VALUE_W'(cv_idx_reg);
                        res_reg.row_empty  <= 1'b0;
                        issue_on_reg       <= 1'b0;
                        dv_reg             <= 1'b0;
                        cv_reg             <= 1'b0;
                        state_reg          <= S_PUSH;
                    end
                end

                S_PUSH:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_reg       <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // a walk always finds its value before the row runs out
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (issue_on_reg || dv_reg || cv_reg))
        else $error("row walk ran dry without a hit");

    // a count and its row total are updated together
    a_inc_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REC_WR) |-> (cnt_we == tot_we))
        else $error("count and row total updated apart");

    // count writes come only from the clearing pass or a record
    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_we |-> (state_reg == S_CLEAR || state_reg == S_REC_WR))
        else $error("unexpected count memory write");

    // no result leaves during the clearing pass
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !rsp_valid)
        else $error("result during clearing pass");
`endif

endmodule

>>> src/mtts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mtts_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the transition table sampler: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench
    import mtts_pkg::*;
();

    localparam int NUM_TABLES  = 8;
    localparam int NUM_VALUES  = 256;
    localparam int COUNT_BITS  = 32;
    localparam longint unsigned CELL_MAX  = (64'd1 << COUNT_BITS) - 64'd1;
    localparam longint unsigned SUM_MAX   = 64'hFFFF_FFFF;
    localparam longint unsigned FRAC_FULL = 64'd65535;

    localparam int RANDOM_ITEMS = 1750;
    localparam int HOT_ROWS     = 6;
    localparam int HOT_REFRESH  = 500;
    localparam int QUIET_FIRST  = 700;
    localparam int QUIET_LAST   = 1000;
    localparam int IDLE_PCT     = 9;
    localparam int MAX_SHOWN    = 10;
    localparam int TAIL_CYCLES  = NUM_VALUES + 40;
    // clearing pass plus every item at its slowest draw, taken several times over
    localparam longint CYCLE_LIMIT = 5_000_000;

    typedef struct {
        req_item_t item;
        bit        fixed;
        rsp_item_t fixed_rsp;
    } stim_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp;

    // predictor copy of the tables: counts kept sparse, totals per row
    int unsigned     cell_count [int unsigned];
    longint unsigned row_sum [NUM_TABLES*NUM_VALUES];

    rsp_item_t pending_draws [$];
    stim_row_t directed_rows [$];

    logic [TSEL_W-1:0]  hot_table [HOT_ROWS];
    logic [VALUE_W-1:0] hot_from  [HOT_ROWS];
    logic [VALUE_W-1:0] hot_base  [HOT_ROWS];

    bit     quiet = 1'b0;
    int     mismatches = 0;
    int     records_sent = 0;
    int     draws_sent = 0;
    int     draws_checked = 0;
    int     empty_seen = 0;
    longint cycle_count = 0;

    markov_transition_table_sampler_core #(
        .TABLES     (NUM_TABLES),
        .VALUES     (NUM_VALUES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    // run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d draws still pending",
                     cycle_count, pending_draws.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic bit row_in_range(req_item_t it);
        return (int'(it.table_select) < NUM_TABLES) && (int'(it.from_value) < NUM_VALUES);
    endfunction

    function automatic int unsigned row_index(req_item_t it);
        return int'(it.table_select) * NUM_VALUES + int'(it.from_value);
    endfunction

    // bump one transition count, holding both the count and the row total at saturation
    function automatic void tally_transition(req_item_t it);
        int unsigned     row;
        int unsigned     slot;
        longint unsigned cur;
        if (!row_in_range(it) || int'(it.to_value) >= NUM_VALUES)
            return;
        row  = row_index(it);
        slot = row * NUM_VALUES + int'(it.to_value);
        cur  = cell_count.exists(slot) ? cell_count[slot] : 0;
        if (cur < CELL_MAX && row_sum[row] < SUM_MAX)
        begin
            cell_count[slot] = 32'(cur + 1);
            row_sum[row]++;
        end
    endfunction

    // inverse-CDF walk: first value where r*total <= cumulative*65535
    function automatic rsp_item_t predict_draw(req_item_t it);
        rsp_item_t       res;
        int unsigned     row;
        int unsigned     slot;
        longint unsigned lhs;
        longint unsigned cum;
        res.next_value = it.from_value;
        res.row_empty  = 1'b1;
        if (row_in_range(it))
        begin
            row = row_index(it);
            if (row_sum[row] != 0)
            begin
                res.row_empty = 1'b0;
                lhs = longint'(it.random_fraction) * row_sum[row];
                cum = 0;
                for (int v = 0; v < NUM_VALUES; v++)
                begin
                    slot = row * NUM_VALUES + v;
                    if (cell_count.exists(slot))
                        cum += cell_count[slot];
                    if (lhs <= cum * FRAC_FULL)
                    begin
                        res.next_value = VALUE_W'(v);
                        break;
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic req_item_t make_req(logic [ACTION_W-1:0] action, int tsel, int from,
                                           int to, int frac);
        req_item_t it;
        it.action          = action;
        it.table_select    = TSEL_W'(tsel);
        it.from_value      = VALUE_W'(from);
        it.to_value        = VALUE_W'(to);
        it.random_fraction = FRAC_W'(frac);
        return it;
    endfunction

    // one directed row; fixed rows carry the answer typed in
    task automatic add_row(logic [ACTION_W-1:0] action, int tsel, int from, int to, int frac,
                           bit fixed = 1'b0, int fix_next = 0, bit fix_empty = 1'b0);
        stim_row_t r;
        r.item                 = make_req(action, tsel, from, to, frac);
        r.fixed                = fixed;
        r.fixed_rsp.next_value = VALUE_W'(fix_next);
        r.fixed_rsp.row_empty  = fix_empty;
        directed_rows.push_back(r);
    endtask

    // concentrate records on a few rows so draws walk populated rows
    task automatic refresh_hot_rows();
        for (int i = 0; i < HOT_ROWS; i++)
        begin
            hot_table[i] = TSEL_W'($urandom_range(NUM_TABLES - 1));
            hot_from[i]  = VALUE_W'($urandom_range(NUM_VALUES - 1));
            hot_base[i]  = VALUE_W'($urandom_range(NUM_VALUES - 1));
        end
    endtask

    function automatic req_item_t random_request();
        req_item_t it;
        int        pick;
        it.table_select    = TSEL_W'($urandom_range(NUM_TABLES - 1));
        it.from_value      = VALUE_W'($urandom_range(255));
        it.to_value        = VALUE_W'($urandom_range(255));
        it.random_fraction = FRAC_W'($urandom_range(65535));
        it.action          = ($urandom_range(99) < 55) ? ACT_RECORD : ACT_DRAW;
        if ($urandom_range(99) < 85)
        begin
            pick            = $urandom_range(HOT_ROWS - 1);
            it.table_select = hot_table[pick];
            it.from_value   = hot_from[pick];
            if (it.action == ACT_RECORD && $urandom_range(1) == 1)
                it.to_value = hot_base[pick] + VALUE_W'($urandom_range(7));
        end
        if (it.action == ACT_DRAW)
        begin
            case ($urandom_range(9))
                0: it.random_fraction = '0;
                1: it.random_fraction = '1;
                default: ;
            endcase
        end
        return it;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_request(req_item_t item, bit fixed, rsp_item_t fixed_rsp);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        if (item.action == ACT_DRAW)
        begin
            pending_draws.push_back(fixed ? fixed_rsp : predict_draw(item));
            draws_sent++;
        end
        else
        begin
            tally_transition(item);
            records_sent++;
        end
        @(negedge clk);
    endtask

    // result side back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    // result checker
    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_draws.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("MISMATCH: unexpected result next_value=%0d row_empty=%0d",
                             rsp.next_value, rsp.row_empty);
            end
            else
            begin
                want = pending_draws.pop_front();
                draws_checked++;
                if (rsp.row_empty === 1'b1)
                    empty_seen++;
                if (rsp.next_value !== want.next_value || rsp.row_empty !== want.row_empty)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"MISMATCH draw %0d: expected next_value=%0d row_empty=%0d,",
                                  " got next_value=%0d row_empty=%0d"},
                                 draws_checked, want.next_value, want.row_empty,
                                 rsp.next_value, rsp.row_empty);
                end
            end
        end
    end

    initial
    begin
        // empty rows after reset, then single-entry and few-entry rows
        add_row(ACT_DRAW,   0,   0,   0,     0, 1'b1,   0, 1'b1);
        add_row(ACT_DRAW,   7, 255, 255, 65535, 1'b1, 255, 1'b1);
        add_row(ACT_DRAW,   5, 170,  85, 16'h5555, 1'b1, 170, 1'b1);
        add_row(ACT_RECORD, 0,   0, 255, 16'hAAAA);
        add_row(ACT_DRAW,   0,   0,  17,     0, 1'b1,   0, 1'b0);   // zero fraction hits 0
        add_row(ACT_DRAW,   0,   0,  17, 65535, 1'b1, 255, 1'b0);
        add_row(ACT_DRAW,   0,   0,  17, 12345, 1'b1, 255, 1'b0);
        add_row(ACT_RECORD, 7, 255,   0, 65535);
        add_row(ACT_DRAW,   7, 255, 200, 65535, 1'b1,   0, 1'b0);
        add_row(ACT_RECORD, 7, 255, 128,     1);
        add_row(ACT_RECORD, 7, 255, 255,     0);
        add_row(ACT_DRAW,   7, 255,   3,     0, 1'b1,   0, 1'b0);
        add_row(ACT_DRAW,   7, 255,   3, 32767);
        add_row(ACT_DRAW,   7, 255,   3, 65535, 1'b1, 255, 1'b0);
        add_row(ACT_RECORD, 3,  90, 165,   100);
        add_row(ACT_RECORD, 3,  90, 165,   200);
        add_row(ACT_RECORD, 3,  90,   1,   300);
        add_row(ACT_DRAW,   3,  90,  64, 16'h8000);
        add_row(ACT_DRAW,   3,  90,  64, 65535, 1'b1, 165, 1'b0);
        add_row(ACT_DRAW,   0,   1, 255, 65535, 1'b1,   1, 1'b1);   // neighbor row still empty
        add_row(ACT_DRAW,   1,   0,   0, 16'h0F0F, 1'b1,   0, 1'b1); // other table still empty
        add_row(ACT_RECORD, 6, 255, 255, 16'h1234);
        add_row(ACT_DRAW,   6, 255,  42,     1, 1'b1, 255, 1'b0);
        add_row(ACT_DRAW,   2,  15, 240, 16'hF0F0, 1'b1,  15, 1'b1);
        add_row(ACT_DRAW,   4, 240,  15, 16'h7FFF, 1'b1, 240, 1'b1);

        // reset, then drive from falling edges
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].item, directed_rows[i].fixed,
                         directed_rows[i].fixed_rsp);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % HOT_REFRESH == 0)
                refresh_hot_rows();
            quiet = (n >= QUIET_FIRST && n < QUIET_LAST);
            send_request(random_request(), 1'b0, '0);
        end
        quiet = 1'b0;
        req_valid <= 1'b0;

        // drain, then let any trailing record finish
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d record and %0d draw transfers; %0d results checked, %0d on empty rows",
                 records_sent, draws_sent, draws_checked, empty_seen);
        $display("Mismatches: %0d, cycles run: %0d", mismatches, cycle_count);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
src/mtts_pkg.sv
src/mtts_ram.sv
src/markov_transition_table_sampler_core.sv
verif/testbench.sv
